[hdl/plist_pkg.sv]
// plist_pkg: shared types and codes of the positional list engine
// used by positional_list_engine; depends on nothing
`default_nettype none

package plist_pkg;

  localparam int unsigned OpWidth     = 2;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned PosWidth    = 5;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [OpWidth-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

[hdl/positional_list_engine.sv]
// positional_list_engine: ordered list of signed words kept in one ram
// depends on plist_pkg and plist_ram
`default_nettype none

// One request at a time, one result transaction per request. The list words
// live in a single ram with one write and one registered read port, so the
// scan and the shift move one entry per cycle. Update, a search or delete on
// an empty list, and any request that fails its range or full check go
// straight to S_FINISH. Search and delete scan from the head until a match or
// the end of the list; a delete that hits then closes the gap in S_SHIFT_DN
// unless the hit was the last entry. Insert moves entries up in S_SHIFT_UP,
// from the tail down to the target index. A new request is taken as soon as
// the previous result sits in the output register; a result held back by
// m_tready keeps the engine in S_FINISH, so the next request waits.

module positional_list_engine #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // op[1:0], value[33:2], position[38:34], zero fill
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata   // status[1:0], found_position[6:2], entry_count[11:7]
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = ((CW > plist_pkg::PosWidth) ? CW : plist_pkg::PosWidth) + 1;
  localparam int unsigned VW = plist_pkg::ValueWidth;

  plist_pkg::state_t  state, state_next;
  plist_pkg::op_t     op_r, op_next;
  plist_pkg::status_t status_r, status_next;
  logic [VW-1:0]      value_r, value_next;
  logic [AW-1:0]      tgt_r, tgt_next;
  logic [AW-1:0]      idx, idx_next;
  logic [CW-1:0]      count, count_next;
  logic [4:0]         found_r, found_next;

  logic [1:0]         out_status;
  logic [4:0]         out_found;
  logic [4:0]         out_count;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [VW-1:0]      wdata;
  logic [AW-1:0]      raddr;
  logic [VW-1:0]      rdata;

  logic                in_fire;
  logic                out_free;
  plist_pkg::op_t      in_op;
  logic [VW-1:0]       in_value;
  logic [PW-1:0]       in_pos;
  logic [PW-1:0]       cnt_ext;
  logic [CW-1:0]       idx_p1;
  logic [CW-1:0]       idx_p2;
  logic                hit;

  assign in_op    = plist_pkg::op_t'(s_tdata[1:0]);
  assign in_value = s_tdata[33:2];
  assign in_pos   = PW'(s_tdata[38:34]);
  assign cnt_ext  = PW'(count);
  assign idx_p1   = CW'(idx) + CW'(1);
  assign idx_p2   = CW'(idx) + CW'(2);
  assign hit      = (rdata == value_r);

  assign s_tready = (state == plist_pkg::S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  plist_ram #(
    .WIDTH(VW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_next  = state;
    op_next     = op_r;
    status_next = status_r;
    value_next  = value_r;
    tgt_next    = tgt_r;
    idx_next    = idx;
    count_next  = count;
    found_next  = found_r;
    we          = 1'b0;
    waddr       = idx;
    wdata       = rdata;
    raddr       = '0;
    unique case (state)
      plist_pkg::S_IDLE: begin
        raddr = (in_op == plist_pkg::OP_INSERT) ? AW'(count - CW'(1)) : '0;
        if (in_fire) begin
          op_next     = in_op;
          value_next  = in_value;
          tgt_next    = AW'(in_pos - PW'(1));
          idx_next    = '0;
          found_next  = '0;
          status_next = plist_pkg::ST_OK;
          state_next  = plist_pkg::S_FINISH;
          unique case (in_op)
            plist_pkg::OP_INSERT: begin
              if (count == CW'(DEPTH)) begin
                status_next = plist_pkg::ST_FULL;
              end else if (in_pos == '0 || in_pos > cnt_ext + PW'(1)) begin
                status_next = plist_pkg::ST_RANGE;
              end else begin
                idx_next   = AW'(count);
                state_next = plist_pkg::S_SHIFT_UP;
              end
            end
            plist_pkg::OP_DELETE, plist_pkg::OP_SEARCH: begin
              if (count == '0) begin
                status_next = plist_pkg::ST_NOT_FOUND;
              end else begin
                state_next = plist_pkg::S_SCAN;
              end
            end
            plist_pkg::OP_UPDATE: begin
              if (in_pos == '0 || in_pos > cnt_ext) begin
                status_next = plist_pkg::ST_RANGE;
              end else begin
                we    = 1'b1;
                waddr = AW'(in_pos - PW'(1));
                wdata = in_value;
              end
            end
            default: begin
              status_next = plist_pkg::ST_OK;
            end
          endcase
        end
      end
      plist_pkg::S_SCAN: begin
        raddr = AW'(idx_p1);
        if (hit) begin
          found_next = 5'(idx_p1);
          if (op_r == plist_pkg::OP_SEARCH) begin
            state_next = plist_pkg::S_FINISH;
          end else if (idx_p1 == count) begin
            count_next = count - CW'(1);
            state_next = plist_pkg::S_FINISH;
          end else begin
            state_next = plist_pkg::S_SHIFT_DN;
          end
        end else if (idx_p1 == count) begin
          status_next = plist_pkg::ST_NOT_FOUND;
          state_next  = plist_pkg::S_FINISH;
        end else begin
          idx_next = AW'(idx_p1);
        end
      end
      plist_pkg::S_SHIFT_DN: begin
        raddr = AW'(idx_p2);
        we    = 1'b1;
        waddr = idx;
        wdata = rdata;
        if (idx_p2 == count) begin
          count_next = count - CW'(1);
          state_next = plist_pkg::S_FINISH;
        end else begin
          idx_next = AW'(idx_p1);
        end
      end
      plist_pkg::S_SHIFT_UP: begin
        raddr = idx - AW'(2);
        we    = 1'b1;
        waddr = idx;
        if (idx == tgt_r) begin
          wdata      = value_r;
          count_next = count + CW'(1);
          state_next = plist_pkg::S_FINISH;
        end else begin
          wdata    = rdata;
          idx_next = idx - AW'(1);
        end
      end
      plist_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = plist_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = plist_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= plist_pkg::S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == plist_pkg::S_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_next;
    status_r <= status_next;
    value_r  <= value_next;
    tgt_r    <= tgt_next;
    idx      <= idx_next;
    found_r  <= found_next;
    if (state == plist_pkg::S_FINISH && out_free) begin
      out_status <= status_r;
      out_found  <= found_r;
      out_count  <= 5'(count);
    end
  end

  assign m_tdata = {4'd0, out_count, out_found, out_status};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count == $past(count)) || (count == $past(count) + CW'(1)) ||
    (count == $past(count) - CW'(1)))
    else $error("entry count moved by more than one");

  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == plist_pkg::S_SCAN || state == plist_pkg::S_SHIFT_DN) |-> (count != '0))
    else $error("scan or gap closing on an empty list");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("second request taken while one is in work");

  a_done_flows: assert property (@(posedge clk) disable iff (rst)
    (state == plist_pkg::S_FINISH && out_free) |=> m_tvalid)
    else $error("finished request gave no result");

endmodule

`default_nettype wire

[hdl/plist_ram.sv]
// plist_ram: generic one-write, one-read synchronous ram with registered read
// no dependencies
`default_nettype none

module plist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[dv/plist_result_check.sv]
// plist_result_check: watches both stream channels of positional_list_engine,
// keeps its own copy of the list, predicts every result and compares it
// depends on plist_pkg for the op and status codes
module plist_result_check #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,  // op[1:0], value[33:2], position[38:34], zero fill
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,  // status[1:0], found_position[6:2], entry_count[11:7]
  output int          fail_count,
  output int          pending,
  output int          list_size,
  output int          results_checked
);

  typedef struct packed {
    plist_pkg::status_t status;
    logic [4:0]         found_pos;
    logic [4:0]         entry_count;
  } list_result_t;

  logic [31:0]  list_words [DEPTH];
  int           list_count;
  list_result_t expected_results [$];

  function automatic list_result_t apply_request(plist_pkg::op_t op, logic [31:0] v,
                                                 logic [4:0] pos);
    list_result_t r;
    int p;
    int idx;
    p = pos;
    r.status = plist_pkg::ST_OK;
    r.found_pos = '0;
    case (op)
      plist_pkg::OP_INSERT: begin
        if (list_count >= DEPTH) begin
          r.status = plist_pkg::ST_FULL;
        end else if (p < 1 || p > list_count + 1) begin
          r.status = plist_pkg::ST_RANGE;
        end else begin
          for (int k = list_count; k > p - 1; k--) list_words[k] = list_words[k - 1];
          list_words[p - 1] = v;
          list_count++;
        end
      end
      plist_pkg::OP_DELETE, plist_pkg::OP_SEARCH: begin
        idx = -1;
        for (int k = 0; k < list_count; k++) begin
          if (idx < 0 && list_words[k] == v) idx = k;
        end
        if (idx < 0) begin
          r.status = plist_pkg::ST_NOT_FOUND;
        end else begin
          r.found_pos = 5'(idx + 1);
          if (op == plist_pkg::OP_DELETE) begin
            for (int k = idx; k + 1 < list_count; k++) list_words[k] = list_words[k + 1];
            list_count--;
          end
        end
      end
      default: begin
        if (p < 1 || p > list_count) r.status = plist_pkg::ST_RANGE;
        else list_words[p - 1] = v;
      end
    endcase
    r.entry_count = 5'(list_count);
    return r;
  endfunction

  task automatic report_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    list_result_t got;
    list_result_t exp;
    if (rst) begin
      list_count = 0;
      expected_results.delete();
      fail_count = 0;
      results_checked = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_request(plist_pkg::op_t'(s_tdata[1:0]),
                                                 s_tdata[33:2], s_tdata[38:34]));
      end
      if (m_tvalid && m_tready) begin
        got.status = plist_pkg::status_t'(m_tdata[1:0]);
        got.found_pos = m_tdata[6:2];
        got.entry_count = m_tdata[11:7];
        if (expected_results.size() == 0) begin
          report_failure($sformatf("result with no request waiting: status %0d found %0d count %0d",
                                   got.status, got.found_pos, got.entry_count));
        end else begin
          exp = expected_results.pop_front();
          results_checked++;
          if (got.status !== exp.status || got.found_pos !== exp.found_pos ||
              got.entry_count !== exp.entry_count) begin
            report_failure($sformatf(
              "result %0d: expected status %0d found %0d count %0d, got status %0d found %0d count %0d",
              results_checked, exp.status, exp.found_pos, exp.entry_count,
              got.status, got.found_pos, got.entry_count));
          end
        end
      end
    end
    pending = expected_results.size();
    list_size = list_count;
  end

endmodule

[dv/positional_list_engine_tb.sv]
// positional_list_engine_tb: drives insert, delete, search and update requests
// with random source gaps and sink stalls, verdict from plist_result_check
// depends on plist_pkg, positional_list_engine and plist_result_check
module positional_list_engine_tb;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned PHASES = 18;
  localparam int unsigned PHASE_ITEMS = 90;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // op[1:0], value[33:2], position[38:34], zero fill
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;       // status[1:0], found_position[6:2], entry_count[11:7]

  int          fail_count;
  int          pending;
  int          list_size;
  int          results_checked;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          op_sent [4];
  logic [31:0] value_pool [6];

  always #5 clk = ~clk;

  positional_list_engine #(.DEPTH(DEPTH)) dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
  );

  plist_result_check #(.DEPTH(DEPTH)) result_check (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .fail_count, .pending, .list_size, .results_checked
  );

  // mostly short idles, now and then a long one
  function automatic int pick_idle(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // ends on a falling edge, ready for the next transaction to be driven
  task automatic idle_source();
    int gap;
    gap = pick_idle(gap_pct);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata <= 40'({$urandom(), $urandom()});
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
  endtask

  task automatic drive_request(plist_pkg::op_t op, logic [31:0] v, logic [4:0] pos);
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, pos, v, op};
    op_sent[op]++;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic request(plist_pkg::op_t op, logic [31:0] v, logic [4:0] pos);
    idle_source();
    drive_request(op, v, pos);
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_idle(stall_pct);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("positional_list_engine test failed");
    $finish;
  end

  initial begin
    plist_pkg::op_t op;
    logic [31:0]    v;
    logic [4:0]     pos;
    int             n;
    int             mix;
    int             r;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list
    request(plist_pkg::OP_SEARCH, 32'd0, 5'd1);
    request(plist_pkg::OP_DELETE, 32'd5, 5'd1);
    request(plist_pkg::OP_UPDATE, 32'd7, 5'd1);
    request(plist_pkg::OP_INSERT, 32'd9, 5'd0);
    request(plist_pkg::OP_INSERT, 32'd9, 5'd2);
    // extremes, append and insert at the head
    request(plist_pkg::OP_INSERT, 32'h8000_0000, 5'd1);
    request(plist_pkg::OP_INSERT, 32'h7fff_ffff, 5'd2);
    request(plist_pkg::OP_INSERT, 32'hffff_ffff, 5'd1);
    request(plist_pkg::OP_SEARCH, 32'h7fff_ffff, 5'd31);
    request(plist_pkg::OP_UPDATE, 32'd0, 5'd3);
    request(plist_pkg::OP_UPDATE, 32'd1, 5'd4);
    request(plist_pkg::OP_DELETE, 32'h8000_0000, 5'd0);
    // fill with duplicates until full
    for (int j = 0; j < 14; j++) begin
      request(plist_pkg::OP_INSERT, $urandom_range(0, 3), 5'($urandom_range(1, j + 3)));
    end
    request(plist_pkg::OP_INSERT, 32'd4, 5'd0);
    request(plist_pkg::OP_INSERT, 32'd4, 5'd5);
    request(plist_pkg::OP_DELETE, 32'd2, 5'd16);
    request(plist_pkg::OP_SEARCH, 32'd3, 5'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      mix = ph % 3;
      gap_pct = 20 * $urandom_range(0, 3);
      stall_pct = 20 * $urandom_range(0, 3);
      foreach (value_pool[k]) value_pool[k] = $urandom();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        idle_source();
        n = list_size;
        r = $urandom_range(0, 99);
        // grow, drain and balanced mixes
        case (mix)
          0: op = r < 55 ? plist_pkg::OP_INSERT : r < 70 ? plist_pkg::OP_DELETE :
                  r < 85 ? plist_pkg::OP_SEARCH : plist_pkg::OP_UPDATE;
          1: op = r < 15 ? plist_pkg::OP_INSERT : r < 65 ? plist_pkg::OP_DELETE :
                  r < 85 ? plist_pkg::OP_SEARCH : plist_pkg::OP_UPDATE;
          default: op = r < 30 ? plist_pkg::OP_INSERT : r < 55 ? plist_pkg::OP_DELETE :
                        r < 80 ? plist_pkg::OP_SEARCH : plist_pkg::OP_UPDATE;
        endcase
        r = $urandom_range(0, 99);
        if (op == plist_pkg::OP_INSERT && r < 85 && n < DEPTH) begin
          pos = 5'($urandom_range(1, n + 1));
        end else if (op == plist_pkg::OP_UPDATE && r < 85 && n > 0) begin
          pos = 5'($urandom_range(1, n));
        end else if (r % 3 == 0) begin
          pos = '0;
        end else begin
          pos = 5'($urandom_range(n + 1, 31));
        end
        r = $urandom_range(0, 19);
        if (r < 16) v = value_pool[r % 6];
        else if (r < 18) v = r[0] ? 32'h8000_0000 : 32'h7fff_ffff;
        else v = $urandom();
        drive_request(op, v, pos);
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("sent %0d insert, %0d delete, %0d search and %0d update requests; %0d results checked",
             op_sent[plist_pkg::OP_INSERT], op_sent[plist_pkg::OP_DELETE],
             op_sent[plist_pkg::OP_SEARCH], op_sent[plist_pkg::OP_UPDATE], results_checked);
    $display("random part ran %0d phases of growth, drain and mixed traffic under varied idling",
             PHASES);
    if (fail_count == 0 && pending == 0) begin
      $display("positional_list_engine test passed");
    end else begin
      $display("positional_list_engine test failed");
    end
    $finish;
  end

endmodule
